>>> rtl/core/hlst_pkg.sv
// Package for the held-lock stack tracker.
// Holds the operation codes, the entry type and the cell control struct.
// Used by hlst_cell and held_lock_stack_tracker.
package hlst_pkg;

    typedef enum logic [1:0] {
        OP_PUSH       = 2'd0,
        OP_RELEASE    = 2'd1,
        OP_QUERY_LOCK = 2'd2,
        OP_QUERY_PID  = 2'd3
    } op_t;

    localparam int ADDR_W  = 32;
    localparam int PID_W   = 32;
    localparam int DEPTH_W = 5;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [PID_W-1:0]  pid;
    } entry_t;

    typedef struct packed {
        logic              push;
        logic              release_hit;
        logic [ADDR_W-1:0] addr;
        logic [PID_W-1:0]  pid;
    } cell_ctrl_t;

endpackage

>>> rtl/core/hlst_cell.sv
// One stack slot of the held-lock tracker: stores an address and a pid.
// Compares against the incoming key and shifts down from its upper neighbor.
// Depends on hlst_pkg.
module hlst_cell import hlst_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  logic       below_valid,
    input  entry_t     upper,
    input  logic       addr_hit_in,
    input  logic       pid_hit_in,
    output entry_t     entry,
    output logic       addr_hit_out,
    output logic       pid_hit_out
);

    logic              valid_reg;
    logic              valid_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic [PID_W-1:0]  pid_reg;
    logic [PID_W-1:0]  pid_next;
    logic              addr_match;
    logic              pid_match;
    logic              shift_en;
    logic              load_en;

    assign addr_match   = valid_reg && (addr_reg == ctrl.addr);
    assign pid_match    = valid_reg && (pid_reg == ctrl.pid);
    assign addr_hit_out = addr_hit_in | addr_match;
    assign pid_hit_out  = pid_hit_in | pid_match;

    // The topmost match sits at or below this slot when no match lies above it.
    assign shift_en = ctrl.release_hit && !addr_hit_in;
    assign load_en  = ctrl.push && !valid_reg && below_valid;

    always_comb begin
        valid_next = valid_reg;
        addr_next  = addr_reg;
        pid_next   = pid_reg;
        if (shift_en) begin
            valid_next = upper.valid;
            addr_next  = upper.addr;
            pid_next   = upper.pid;
        end else if (load_en) begin
            valid_next = 1'b1;
            addr_next  = ctrl.addr;
            pid_next   = ctrl.pid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        pid_reg  <= pid_next;
    end

    assign entry = '{valid: valid_reg, addr: addr_reg, pid: pid_reg};

endmodule

>>> rtl/core/held_lock_stack_tracker.sv
// Held-lock stack tracker: a row of STACK_DEPTH slots compared in parallel.
// The result of an accepted transaction is registered in the cycle after it is accepted.
// Throughput is one transaction per cycle, set by the combinational compare
// chain across all slots, whenever the result side takes each result.
// Synchronous active-low reset empties the stack; stored keys are not cleared.
// Depends on hlst_pkg and hlst_cell.
module held_lock_stack_tracker import hlst_pkg::*; #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // lock_address [31:0], owner_pid [63:32]
    input  logic [1:0]  s_tuser,   // op [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // found [0], depth [5:1], overflow [6], zero [7]
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    cell_ctrl_t           ctrl;
    entry_t               entries [STACK_DEPTH+1];
    logic [STACK_DEPTH:0] addr_hit;
    logic [STACK_DEPTH:0] pid_hit;
    logic [STACK_DEPTH-1:0] below_valid;
    logic [STACK_DEPTH-1:0] valid_vec;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [7:0]       m_data_reg;
    logic [7:0]       m_data_next;

    logic             accept;
    op_t              op;
    logic             full;
    logic             found;
    logic             overflow;

    assign op       = op_t'(s_tuser);
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(STACK_DEPTH));

    assign ctrl.push        = accept && (op == OP_PUSH);
    assign ctrl.release_hit = accept && (op == OP_RELEASE) && addr_hit[0];
    assign ctrl.addr        = s_tdata[31:0];
    assign ctrl.pid         = s_tdata[63:32];

    assign entries[STACK_DEPTH] = '0;
    assign addr_hit[STACK_DEPTH] = 1'b0;
    assign pid_hit[STACK_DEPTH]  = 1'b0;
    assign below_valid = {valid_vec[STACK_DEPTH-2:0], 1'b1};

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        hlst_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .below_valid (below_valid[i]),
            .upper       (entries[i+1]),
            .addr_hit_in (addr_hit[i+1]),
            .pid_hit_in  (pid_hit[i+1]),
            .entry       (entries[i]),
            .addr_hit_out(addr_hit[i]),
            .pid_hit_out (pid_hit[i])
        );
        assign valid_vec[i] = entries[i].valid;
    end

    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        found        = 1'b0;
        overflow     = 1'b0;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            unique case (op)
                OP_PUSH: begin
                    if (full) begin
                        overflow = 1'b1;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_RELEASE: begin
                    found = addr_hit[0];
                    if (addr_hit[0]) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                OP_QUERY_LOCK: found = addr_hit[0];
                OP_QUERY_PID:  found = pid_hit[0];
                default:       found = 1'b0;
            endcase
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, overflow, DEPTH_W'(count_next), found};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // The slot valid bits always count exactly the entries held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(count_reg))
        else $error("slot valid bits disagree with entry count");

    // Held slots stay packed at the bottom of the row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_vec + STACK_DEPTH'(1)) & valid_vec) == '0)
        else $error("held slots are not contiguous");

    // A push onto a full stack leaves the count unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == OP_PUSH && full) |=> $stable(count_reg))
        else $error("dropped push changed the entry count");

    // A release that finds its lock removes exactly one entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.release_hit) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("release hit did not remove one entry");

    // Overflow is only reported together with a miss.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[6]) |-> !m_data_reg[0])
        else $error("overflow reported with found set");

endmodule
